@@ design/bfie_pkg.sv @@
// Shared types and constants for the bit field insert and extract buffer.
`timescale 1ns / 1ps
`default_nettype none

package bfie_pkg;

  localparam int unsigned POS_W  = 13;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned NPOS_W = 14;
  localparam int unsigned SPAN_W = 40;
  localparam int unsigned IDX_W  = 3;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [NPOS_W-1:0] npos_t;
  typedef logic [SPAN_W-1:0] span_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

`default_nettype wire

@@ design/bit_field_buffer_insert_extract.sv @@
// Top level of the bit field insert and extract buffer over a byte memory.
`timescale 1ns / 1ps
`default_nettype none

// A request is a transfer at a rising edge where start is high and busy is low.
// It carries an operation, a bit position, a bit count and a value. An insert ORs
// the low bits of the value into the byte memory, bit 0 of each byte first; an
// extract gathers the same bits into read_value_o. Each request produces one
// result, shown for exactly one cycle with done_o high; the receiver cannot
// stall it. A refused request or one with a zero count answers in the cycle after
// its transfer. Otherwise the field covers N bytes (one to five); the block
// reads one byte per cycle through the single memory read port and, for an
// insert, modifies and writes each byte back. done_o rises once the read data
// of the last byte is back, and busy drops in that same cycle, letting the next
// request be taken while the result is shown. After reset the block sweeps
// the memory to zero, one byte a cycle, with busy high before the first request.
module bit_field_buffer_insert_extract #(
  parameter int unsigned STORE_BYTES    = 1024,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  wire                   operation_i,
  input  wire bfie_pkg::pos_t   bit_position_i,
  input  wire bfie_pkg::val_t   write_value_i,
  input  wire bfie_pkg::cnt_t   bit_count_i,
  output logic                  done_o,
  output bfie_pkg::val_t        read_value_o,
  output bfie_pkg::npos_t       next_position_o,
  output logic                  out_of_range_o
);
  import bfie_pkg::*;

  localparam int unsigned ADDR_W    = $clog2(STORE_BYTES);
  localparam int unsigned WIDE_W    = 20;
  localparam int unsigned STORE_BITS = STORE_BYTES * 8;
  localparam int unsigned LIM_W     = 7;

  logic [7:0] mem [STORE_BYTES];

  state_e state_q, state_d;

  logic              op_q, op_d;
  pos_t              pos_q, pos_d;
  cnt_t              cnt_q, cnt_d;
  span_t             ins_q, ins_d;
  val_t              mask_q, mask_d;
  idx_t              nbytes_q, nbytes_d;
  idx_t              rd_idx_q, rd_idx_d;
  idx_t              wr_idx_q, wr_idx_d;
  logic              rvalid_q, rvalid_d;
  span_t             acc_q, acc_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [7:0]        rdata_q;

  logic  done_q, done_d;
  val_t  rv_q, rv_d;
  npos_t np_q, np_d;
  logic  oor_q, oor_d;

  logic              accept;
  logic              refuse;
  logic              immediate;
  cnt_t              cnt_eff;
  npos_t             sum;
  logic [WIDE_W-1:0] base_wide;
  logic [32:0]       mask_wide;
  logic [6:0]        span_len;
  span_t             acc_shift;
  logic              last;
  logic              clear_done;

  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign sum       = NPOS_W'(bit_position_i) + NPOS_W'(bit_count_i);
  assign refuse    = (LIM_W'(bit_count_i) > LIM_W'(MAX_FIELD_BITS)) ||
                     (WIDE_W'(sum) > WIDE_W'(STORE_BITS));
  assign cnt_eff   = (bit_count_i > CNT_W'(VAL_W)) ? CNT_W'(VAL_W) : bit_count_i;
  assign immediate = refuse || (cnt_eff == '0);
  assign base_wide = WIDE_W'(bit_position_i >> 3);
  assign mask_wide = (33'd1 << cnt_eff) - 33'd1;
  assign span_len  = 7'(bit_position_i[2:0]) + 7'(cnt_eff) + 7'd7;
  assign last      = rvalid_q && (wr_idx_q == nbytes_q - idx_t'(1));
  assign clear_done = (clr_addr_q == ADDR_W'(STORE_BYTES - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !immediate) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = base_q + ADDR_W'(rd_idx_q);
    mem_we    = 1'b0;
    mem_waddr = base_q + ADDR_W'(wr_idx_q);
    mem_wdata = rdata_q | ins_q[8*wr_idx_q +: 8];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_re = 1'b0;
      end
      ST_RUN: begin
        mem_re = (rd_idx_q < nbytes_q);
        mem_we = rvalid_q && (op_q == OP_INSERT);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    op_d       = op_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    ins_d      = ins_q;
    mask_d     = mask_q;
    nbytes_d   = nbytes_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    acc_d      = acc_q;
    base_d     = base_q;
    clr_addr_d = clr_addr_q;
    rvalid_d   = mem_re;
    done_d     = 1'b0;
    rv_d       = rv_q;
    np_d       = np_q;
    oor_d      = oor_q;
    acc_shift  = '0;
    if (state_q == ST_CLEAR) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
    end
    if (accept) begin
      op_d     = operation_i;
      pos_d    = bit_position_i;
      cnt_d    = bit_count_i;
      mask_d   = mask_wide[VAL_W-1:0];
      ins_d    = SPAN_W'(write_value_i & mask_wide[VAL_W-1:0]) << bit_position_i[2:0];
      nbytes_d = span_len[5:3];
      rd_idx_d = '0;
      wr_idx_d = '0;
      acc_d    = '0;
      base_d   = base_wide[ADDR_W-1:0];
      if (immediate) begin
        done_d = 1'b1;
        rv_d   = '0;
        np_d   = refuse ? NPOS_W'(bit_position_i) : sum;
        oor_d  = refuse;
      end
    end
    if (state_q == ST_RUN) begin
      if (mem_re) begin
        rd_idx_d = rd_idx_q + idx_t'(1);
      end
      if (rvalid_q) begin
        acc_d[8*wr_idx_q +: 8] = rdata_q;
        wr_idx_d = wr_idx_q + idx_t'(1);
      end
      acc_shift = acc_d >> pos_q[2:0];
      if (last) begin
        done_d = 1'b1;
        rv_d   = (op_q == OP_EXTRACT) ? (acc_shift[VAL_W-1:0] & mask_q) : '0;
        np_d   = NPOS_W'(pos_q) + NPOS_W'(cnt_q);
        oor_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      nbytes_q   <= '0;
      rvalid_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      nbytes_q   <= nbytes_d;
      rvalid_q   <= rvalid_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
    ins_q  <= ins_d;
    mask_q <= mask_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    rv_q   <= rv_d;
    np_q   <= np_d;
    oor_q  <= oor_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign done_o          = done_q;
  assign read_value_o    = rv_q;
  assign next_position_o = np_q;
  assign out_of_range_o  = oor_q;

  // A refused request must return an empty value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (read_value_o == '0))
    else $error("Refused request returned a nonzero value.");

  // The memory is only written by the clearing sweep or by an insert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == ST_RUN)) |-> (op_q == OP_INSERT))
    else $error("Memory written during an extract.");

  // Read data is consumed only in the cycle after a read was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> ($past(mem_re) && (state_q == ST_RUN)))
    else $error("Read data valid without a preceding read.");

  // A result always follows either an immediate answer or the last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(accept) || $past(last)))
    else $error("Result strobe without a request behind it.");

endmodule

`default_nettype wire
